/* src/rsadi_pkg.sv */
package rsadi_pkg;

  // Default widths of the pulse and time fields.
  localparam int unsigned PULSE_BITS_DEF = 12;
  localparam int unsigned TIME_BITS_DEF  = 32;
  localparam int unsigned SINCE_BITS     = 16;

  // Configuration register file.
  localparam int unsigned NUM_REGS     = 8;
  localparam int unsigned REG_IDX_BITS = 3;

  // Entries of the queue between classifier and sequencer.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Result bus width, padded to whole bytes.
  localparam int unsigned OUT_DATA_BITS = 8;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_ROLL_FS_MIN     = 3'd0,
    REG_ROLL_FS_MAX     = 3'd1,
    REG_PITCH_FS_MIN    = 3'd2,
    REG_PITCH_FS_MAX    = 3'd3,
    REG_THROTTLE_FS_MIN = 3'd4,
    REG_THROTTLE_FS_MAX = 3'd5,
    REG_KEY_FS_MIN      = 3'd6,
    REG_KEY_FS_MAX      = 3'd7
  } reg_idx_e;

  // Reset values of the failsafe windows, in microseconds.
  localparam int unsigned ROLL_FS_MIN_RST     = 998;
  localparam int unsigned ROLL_FS_MAX_RST     = 1002;
  localparam int unsigned PITCH_FS_MIN_RST    = 1995;
  localparam int unsigned PITCH_FS_MAX_RST    = 2000;
  localparam int unsigned THROTTLE_FS_MIN_RST = 1032;
  localparam int unsigned THROTTLE_FS_MAX_RST = 1036;
  localparam int unsigned KEY_FS_MIN_RST      = 998;
  localparam int unsigned KEY_FS_MAX_RST      = 1002;

  // Fixed stick windows, in microseconds.
  localparam int unsigned PREP_MIN_US         = 1900;
  localparam int unsigned PREP_MAX_US         = 2000;
  localparam int unsigned ARM_THR_MIN_US      = 1000;
  localparam int unsigned ARM_THR_MAX_US      = 1050;
  localparam int unsigned ARM_RP_MIN_US       = 940;
  localparam int unsigned ARM_RP_MAX_US       = 1060;
  localparam int unsigned DISARM_ROLL_MIN_US  = 1950;
  localparam int unsigned DISARM_ROLL_MAX_US  = 2000;
  localparam int unsigned DISARM_PITCH_MIN_US = 950;
  localparam int unsigned DISARM_PITCH_MAX_US = 1050;

  // Hold time for arm and disarm, and the signal loss timeout, in ms.
  localparam int unsigned HOLD_MS = 3000;
  localparam int unsigned LOSS_MS = 25;

  // Classification of one update, produced by the front end.
  typedef struct packed {
    logic frame_valid;
    logic win_all;
    logic thr_win;
    logic key_win;
    logic prep_key;
    logic arm_sticks;
    logic disarm_sticks;
    logic sig_loss;
  } cls_t;

  // Result flags; armed sits in bit 0.
  typedef struct packed {
    logic key_in_fs;
    logic throttle_in_fs;
    logic can_arm;
    logic arm_prep;
    logic signal_failsafe;
    logic combined_failsafe;
    logic armed;
  } result_t;

endpackage

/* src/rsadi_fifo.sv */
module rsadi_fifo
  import rsadi_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* src/rsadi_front.sv */
module rsadi_front
  import rsadi_pkg::*;
#(
  parameter int unsigned PULSE_BITS   = PULSE_BITS_DEF,
  parameter int unsigned TIME_BITS    = TIME_BITS_DEF,
  parameter int unsigned IN_DATA_BITS = 96
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  logic [IN_DATA_BITS-1:0] s_axis_tdata_i,
  input  logic                    s_axis_tuser_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [REG_IDX_BITS-1:0] cfg_index_i,
  input  logic [PULSE_BITS-1:0]   cfg_data_i,
  output logic                    push_o,
  output cls_t                    push_cls_o,
  output logic [TIME_BITS-1:0]    push_now_o,
  input  logic                    queue_full_i
);

  typedef logic [PULSE_BITS-1:0] pulse_t;

  localparam pulse_t PrepMin   = PULSE_BITS'(PREP_MIN_US);
  localparam pulse_t PrepMax   = PULSE_BITS'(PREP_MAX_US);
  localparam pulse_t ArmThrMin = PULSE_BITS'(ARM_THR_MIN_US);
  localparam pulse_t ArmThrMax = PULSE_BITS'(ARM_THR_MAX_US);
  localparam pulse_t ArmRpMin  = PULSE_BITS'(ARM_RP_MIN_US);
  localparam pulse_t ArmRpMax  = PULSE_BITS'(ARM_RP_MAX_US);
  localparam pulse_t DisRollMn = PULSE_BITS'(DISARM_ROLL_MIN_US);
  localparam pulse_t DisRollMx = PULSE_BITS'(DISARM_ROLL_MAX_US);
  localparam pulse_t DisPitMn  = PULSE_BITS'(DISARM_PITCH_MIN_US);
  localparam pulse_t DisPitMx  = PULSE_BITS'(DISARM_PITCH_MAX_US);
  localparam logic [SINCE_BITS-1:0] LossLimit = SINCE_BITS'(LOSS_MS);

  function automatic pulse_t reg_reset_val(reg_idx_e idx);
    pulse_t val;
    case (idx)
      REG_ROLL_FS_MIN:     val = PULSE_BITS'(ROLL_FS_MIN_RST);
      REG_ROLL_FS_MAX:     val = PULSE_BITS'(ROLL_FS_MAX_RST);
      REG_PITCH_FS_MIN:    val = PULSE_BITS'(PITCH_FS_MIN_RST);
      REG_PITCH_FS_MAX:    val = PULSE_BITS'(PITCH_FS_MAX_RST);
      REG_THROTTLE_FS_MIN: val = PULSE_BITS'(THROTTLE_FS_MIN_RST);
      REG_THROTTLE_FS_MAX: val = PULSE_BITS'(THROTTLE_FS_MAX_RST);
      REG_KEY_FS_MIN:      val = PULSE_BITS'(KEY_FS_MIN_RST);
      REG_KEY_FS_MAX:      val = PULSE_BITS'(KEY_FS_MAX_RST);
      default:             val = '0;
    endcase
    return val;
  endfunction

  function automatic logic in_win(pulse_t v, pulse_t lo, pulse_t hi);
    return (v >= lo) && (v <= hi);
  endfunction

  pulse_t                cfg_q [NUM_REGS];
  pulse_t                roll, pitch, thr, key;
  logic [SINCE_BITS-1:0] since;
  logic                  r_win, p_win;

  // Window registers; all eight are always writable.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_q[i] <= reg_reset_val(reg_idx_e'(REG_IDX_BITS'(i)));
      end
    end else if (cfg_valid_i) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  assign roll       = s_axis_tdata_i[0 +: PULSE_BITS];
  assign pitch      = s_axis_tdata_i[PULSE_BITS +: PULSE_BITS];
  assign thr        = s_axis_tdata_i[2*PULSE_BITS +: PULSE_BITS];
  assign key        = s_axis_tdata_i[3*PULSE_BITS +: PULSE_BITS];
  assign since      = s_axis_tdata_i[4*PULSE_BITS +: SINCE_BITS];
  assign push_now_o = s_axis_tdata_i[4*PULSE_BITS+SINCE_BITS +: TIME_BITS];

  assign r_win = in_win(roll, cfg_q[REG_ROLL_FS_MIN], cfg_q[REG_ROLL_FS_MAX]);
  assign p_win = in_win(pitch, cfg_q[REG_PITCH_FS_MIN], cfg_q[REG_PITCH_FS_MAX]);

  always_comb begin
    push_cls_o.frame_valid   = s_axis_tuser_i;
    push_cls_o.thr_win       = in_win(thr, cfg_q[REG_THROTTLE_FS_MIN],
                                      cfg_q[REG_THROTTLE_FS_MAX]);
    push_cls_o.key_win       = in_win(key, cfg_q[REG_KEY_FS_MIN], cfg_q[REG_KEY_FS_MAX]);
    push_cls_o.win_all       = r_win && p_win && push_cls_o.thr_win && push_cls_o.key_win;
    push_cls_o.prep_key      = in_win(key, PrepMin, PrepMax);
    push_cls_o.arm_sticks    = in_win(thr, ArmThrMin, ArmThrMax) &&
                               in_win(roll, ArmRpMin, ArmRpMax) &&
                               in_win(pitch, ArmRpMin, ArmRpMax);
    push_cls_o.disarm_sticks = in_win(roll, DisRollMn, DisRollMx) &&
                               in_win(pitch, DisPitMn, DisPitMx);
    push_cls_o.sig_loss      = (since > LossLimit);
  end

  assign s_axis_tready_o = !queue_full_i;
  assign push_o          = s_axis_tvalid_i && !queue_full_i;

endmodule

/* src/rsadi_back.sv */
module rsadi_back
  import rsadi_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cls_t                 in_cls_i,
  input  logic [TIME_BITS-1:0] in_now_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output result_t              out_result_o
);

  typedef logic [TIME_BITS-1:0] time_t;

  localparam time_t HoldTime = TIME_BITS'(HOLD_MS);

  logic    armed_q, armed_d;
  logic    comb_q, comb_d;
  logic    sig_q, sig_d;
  logic    thr_q, thr_d;
  logic    key_q, key_d;
  logic    prep_q, prep_d;
  logic    hold_q, hold_d;
  logic    done_q, done_d;
  time_t   start_q, start_d;
  logic    dhold_q, dhold_d;
  time_t   dstart_q, dstart_d;
  logic    out_valid_q;
  result_t result_q, result_d;
  logic    pop;
  logic    arm_el_ok, dis_el_ok;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign pop        = in_valid_i && in_ready_o;

  // Elapsed times wrap with the clock.
  assign arm_el_ok = (time_t'(in_now_i - start_q) >= HoldTime);
  assign dis_el_ok = (time_t'(in_now_i - dstart_q) >= HoldTime);

  always_comb begin
    logic armed_mid;
    armed_mid = armed_q;
    comb_d    = comb_q;
    sig_d     = sig_q;
    thr_d     = thr_q;
    key_d     = key_q;
    prep_d    = prep_q;
    hold_d    = hold_q;
    done_d    = done_q;
    start_d   = start_q;
    dhold_d   = dhold_q;
    dstart_d  = dstart_q;

    if (in_cls_i.frame_valid) begin
      comb_d = in_cls_i.win_all;
      thr_d  = in_cls_i.thr_win;
      key_d  = in_cls_i.key_win;
      prep_d = in_cls_i.prep_key;
      sig_d  = 1'b0;

      // The arm timer only lives while prep and the arm sticks are held; a cleared
      // timer has a zero start and done, so clearing it again changes nothing.
      if (in_cls_i.prep_key && in_cls_i.arm_sticks) begin
        if (!hold_q) begin
          hold_d  = 1'b1;
          start_d = in_now_i;
          done_d  = 1'b0;
        end else if (!done_q && arm_el_ok && !armed_q) begin
          armed_mid = 1'b1;
          done_d    = 1'b1;
        end
      end else begin
        hold_d  = 1'b0;
        done_d  = 1'b0;
        start_d = '0;
      end

      // Disarm hold, seen with the armed state of this same frame.
      if (armed_mid) begin
        if (in_cls_i.disarm_sticks) begin
          if (!dhold_q) begin
            dhold_d  = 1'b1;
            dstart_d = in_now_i;
          end else if (dis_el_ok) begin
            armed_mid = 1'b0;
            dhold_d   = 1'b0;
            dstart_d  = '0;
          end
        end else if (dhold_q) begin
          dhold_d  = 1'b0;
          dstart_d = '0;
        end
      end
    end else begin
      comb_d  = 1'b0;
      thr_d   = 1'b0;
      key_d   = 1'b0;
      prep_d  = 1'b0;
      hold_d  = 1'b0;
      done_d  = 1'b0;
      start_d = '0;
      sig_d   = sig_q || in_cls_i.sig_loss;
    end
    armed_d = armed_mid;

    result_d.armed             = armed_d;
    result_d.combined_failsafe = comb_d;
    result_d.signal_failsafe   = sig_d;
    result_d.arm_prep          = prep_d;
    // A hold that starts on this frame has zero elapsed time, so only a
    // hold carried over can qualify; its start is then unchanged.
    result_d.can_arm           = prep_d && hold_d && hold_q && arm_el_ok;
    result_d.throttle_in_fs    = thr_d;
    result_d.key_in_fs         = key_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      comb_q      <= 1'b0;
      sig_q       <= 1'b0;
      thr_q       <= 1'b0;
      key_q       <= 1'b0;
      prep_q      <= 1'b0;
      hold_q      <= 1'b0;
      done_q      <= 1'b0;
      start_q     <= '0;
      dhold_q     <= 1'b0;
      dstart_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        armed_q  <= armed_d;
        comb_q   <= comb_d;
        sig_q    <= sig_d;
        thr_q    <= thr_d;
        key_q    <= key_d;
        prep_q   <= prep_d;
        hold_q   <= hold_d;
        done_q   <= done_d;
        start_q  <= start_d;
        dhold_q  <= dhold_d;
        dstart_q <= dstart_d;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = result_q;

endmodule

/* src/rc_stick_arm_disarm_interlock.sv */
// Stick arm/disarm interlock for an RC receiver. Each input item is one
// receiver update; the block answers every item with exactly one result item
// carrying seven status flags taken after that update. The block sustains one
// item per clock while the master side takes results: a classifier checks
// the pulse widths against the eight failsafe window registers and the fixed
// stick windows as the item is accepted and writes the outcome into a
// two-entry queue, and a sequencer pops one entry per cycle while its result
// register is free or being drained, advances the arm and disarm timers and
// registers the result. A result passes through the queue and the result
// register before it appears on the master side. The sequencer keeps popping
// while the result register is being drained, so both sides may stall
// independently. Window registers are written through the cfg channel, which
// is always ready; write them only while no item is in flight.
module rc_stick_arm_disarm_interlock
  import rsadi_pkg::*;
#(
  parameter int unsigned PULSE_BITS = PULSE_BITS_DEF,
  parameter int unsigned TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,

  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // tdata from bit 0 up: roll_us, pitch_us, throttle_us, key_us (PULSE_BITS
  // each), since_frame_ms (16), now_ms (TIME_BITS), zero padding.
  input  logic [((4*PULSE_BITS+SINCE_BITS+TIME_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // tuser: frame_valid.
  input  logic                    s_axis_tuser_i,

  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  // tdata from bit 0 up: armed, combined_failsafe, signal_failsafe,
  // arm_prep, can_arm, throttle_in_fs, key_in_fs, zero padding.
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata_o,

  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [REG_IDX_BITS-1:0] cfg_index_i,
  input  logic [PULSE_BITS-1:0]   cfg_data_i
);

  localparam int unsigned IN_DATA_BITS = ((4*PULSE_BITS + SINCE_BITS + TIME_BITS + 7) / 8) * 8;
  localparam int unsigned QW = $bits(cls_t) + TIME_BITS;

  logic                 push, queue_full, queue_empty, pop;
  cls_t                 push_cls, pop_cls;
  logic [TIME_BITS-1:0] push_now, pop_now;
  result_t              result;

  rsadi_front #(
    .PULSE_BITS   (PULSE_BITS),
    .TIME_BITS    (TIME_BITS),
    .IN_DATA_BITS (IN_DATA_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .push_o          (push),
    .push_cls_o      (push_cls),
    .push_now_o      (push_now),
    .queue_full_i    (queue_full)
  );

  // The queue carries the classification and the timestamp of each item.
  rsadi_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_cls, push_now}),
    .full_o      (queue_full),
    .pop_i       (pop),
    .pop_data_o  ({pop_cls, pop_now}),
    .empty_o     (queue_empty)
  );

  rsadi_back #(
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (!queue_empty),
    .in_ready_o   (pop),
    .in_cls_i     (pop_cls),
    .in_now_i     (pop_now),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_result_o (result)
  );

  assign m_axis_tdata_o = OUT_DATA_BITS'(result);

endmodule

/* src/rsadi_checker.sv */
module rsadi_checker
  import rsadi_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     m_axis_tvalid_o,
  input logic                     m_axis_tready_i,
  input logic [OUT_DATA_BITS-1:0] m_axis_tdata_o,
  input logic                     cfg_valid_i,
  input logic                     cfg_ready_o
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed or dropped while stalled");

  // can_arm needs arm_prep.
  a_can_arm_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !m_axis_tdata_o[4] || m_axis_tdata_o[3])
    else $error("can_arm without arm_prep");

  // The combined failsafe covers the throttle and key windows.
  a_comb_parts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !m_axis_tdata_o[1] || (m_axis_tdata_o[5] && m_axis_tdata_o[6]))
    else $error("combined failsafe without throttle and key in window");

  // Signal failsafe only follows a lost frame, which clears the combined
  // failsafe and prep.
  a_sig_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[2] && (m_axis_tdata_o[1] || m_axis_tdata_o[3])))
    else $error("signal failsafe together with combined failsafe or prep");

  // The config channel never stalls.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write stalled");

endmodule

bind rc_stick_arm_disarm_interlock rsadi_checker u_rsadi_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .cfg_valid_i     (cfg_valid_i),
  .cfg_ready_o     (cfg_ready_o)
);
